@@ design/lrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared widths, constants, register indexes and fixed-point helpers for the
// lidar range to point projection block.
// ----------------------------------------------------------------------------
package lrp_pkg;

  // Field widths
  localparam int RANGE_W  = 16;
  localparam int INDEX_W  = 9;
  localparam int INTEN_W  = 8;
  localparam int POS_W    = 32;
  localparam int TOFF_W   = 41;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Default point count per packet
  localparam int MAX_POINTS_DEF = 300;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE_BIAS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_WINDOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEVATION        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT             = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_OFFSETS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP        = 3'd6;

  // Angle path: Q4.28 radians, sines and cosines in Q2.30
  localparam int ANG_W  = 42;
  localparam int TRIG_W = 32;
  localparam int CW     = 34;
  localparam int CORDIC_STEPS = 28;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;

  localparam logic [31:0]        TWO_PI_Q28  = 32'd1686629713;
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

  // Modulo 2*pi: offset by 656 turns so the angle is positive, then estimate
  // the turn count from the top bits with a reciprocal (never above the truth,
  // at most one below).
  localparam logic [ANG_W-1:0] RED_OFS = 42'd1106429091728;
  localparam int RED_LO    = 20;
  localparam int RED_HI_W  = ANG_W - RED_LO;
  localparam int RECIP_W   = 14;
  localparam logic [RECIP_W-1:0] RED_RECIP = 14'd10430;
  localparam int RED_SHIFT = 24;
  localparam int QP_W      = RED_HI_W + RECIP_W;
  localparam int QE_W      = QP_W - RED_SHIFT;

  // Reduction (5) + CORDIC iterations + output sign stage
  localparam int SINCOS_LAT = 5 + CORDIC_STEPS + 1;

  localparam logic signed [31:0] ATAN_Q28 [CORDIC_STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
    32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2
  };

  // Q30 product rounding: (p + 2^29) >> 30, floor shift
  function automatic logic signed [37:0] rnd30(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = p + 68'sd536870912;
    return t[67:30];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] res;
    if (v > 38'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

@@ design/lrp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_in_if
// Range sample channel: valid/ready handshake with count, index, intensity.
// ----------------------------------------------------------------------------
interface lrp_in_if;
  import lrp_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_count;
  logic [INDEX_W-1:0] point_index;
  logic [INTEN_W-1:0] intensity;

  modport source (output valid, range_count, point_index, intensity, input ready);
  modport sink   (input valid, range_count, point_index, intensity, output ready);
endinterface

@@ design/lrp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_out_if
// Point channel: valid/ready handshake with coordinates, intensity and time.
// ----------------------------------------------------------------------------
interface lrp_out_if;
  import lrp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [INTEN_W-1:0]      point_intensity;
  logic [TOFF_W-1:0]       time_offset;
  logic [INDEX_W-1:0]      source_index;

  modport source (output valid, pos_x, pos_y, pos_z, point_intensity, time_offset,
                  source_index, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, point_intensity, time_offset,
                  source_index, output ready);
endinterface

@@ design/lrp_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface lrp_cfg_if;
  import lrp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/lrp_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_sincos
// Pipelined sine/cosine: modulo 2*pi reduction, quadrant fold and a 28-stage
// CORDIC, one iteration per stage. All stages share one enable.
// ----------------------------------------------------------------------------
module lrp_sincos (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lrp_pkg::ANG_W-1:0]  ang,
  output logic signed [lrp_pkg::TRIG_W-1:0] sin_o,
  output logic signed [lrp_pkg::TRIG_W-1:0] cos_o
);
  import lrp_pkg::*;

  localparam int LAST = CORDIC_STEPS - 1;

  logic [ANG_W:0]        u_sum;
  logic [ANG_W-1:0]      u1_r, u2_r;
  logic [QP_W-1:0]       qprod;
  logic [QE_W-1:0]       qe_r;
  logic [ANG_W-1:0]      qm, rdiff;
  logic [31:0]           r3_r, rm;
  logic signed [31:0]    r4_nxt, r4_r;
  logic signed [31:0]    z5_nxt, z5_r;
  logic                  f5_nxt, f5_r;
  logic signed [CW-1:0]  x_r [CORDIC_STEPS];
  logic signed [CW-1:0]  y_r [CORDIC_STEPS];
  logic signed [31:0]    z_r [CORDIC_STEPS];
  logic                  f_r [CORDIC_STEPS];
  logic signed [CW-1:0]  sin_full, cos_full;

  // Offset by whole turns, estimate turn count, remove it
  assign u_sum = {ang[ANG_W-1], ang} + {1'b0, RED_OFS};
  assign qprod = QP_W'(u1_r[ANG_W-1:RED_LO]) * QP_W'(RED_RECIP);
  assign qm    = ANG_W'(qe_r) * ANG_W'(TWO_PI_Q28);
  assign rdiff = u2_r - qm;

  // One correction subtract, then move into (-pi, pi]
  always_comb begin
    rm = (r3_r >= TWO_PI_Q28) ? r3_r - TWO_PI_Q28 : r3_r;
    if (rm > $unsigned(PI_Q28)) begin
      r4_nxt = $signed(rm - TWO_PI_Q28);
    end else begin
      r4_nxt = $signed(rm);
    end
  end

  // Fold into the right half plane, note the sign flip
  always_comb begin
    if (r4_r > HALF_PI_Q28) begin
      z5_nxt = r4_r - PI_Q28;
      f5_nxt = 1'b1;
    end else if (r4_r < -HALF_PI_Q28) begin
      z5_nxt = r4_r + PI_Q28;
      f5_nxt = 1'b1;
    end else begin
      z5_nxt = r4_r;
      f5_nxt = 1'b0;
    end
  end

  // Reduction stages
  always_ff @(posedge clk) begin
    if (en) begin
      u1_r <= u_sum[ANG_W-1:0];
      u2_r <= u1_r;
      qe_r <= qprod[QP_W-1:RED_SHIFT];
      r3_r <= rdiff[31:0];
      r4_r <= r4_nxt;
      z5_r <= z5_nxt;
      f5_r <= f5_nxt;
    end
  end

  // CORDIC rotation stages
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] ix, iy;
    logic signed [31:0]   iz;
    logic                 iflip;

    if (i == 0) begin : g_first
      assign ix    = CORDIC_GAIN;
      assign iy    = '0;
      assign iz    = z5_r;
      assign iflip = f5_r;
    end else begin : g_next
      assign ix    = x_r[i-1];
      assign iy    = y_r[i-1];
      assign iz    = z_r[i-1];
      assign iflip = f_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (iz >= 0) begin
          x_r[i] <= ix - (iy >>> i);
          y_r[i] <= iy + (ix >>> i);
          z_r[i] <= iz - ATAN_Q28[i];
        end else begin
          x_r[i] <= ix + (iy >>> i);
          y_r[i] <= iy - (ix >>> i);
          z_r[i] <= iz + ATAN_Q28[i];
        end
        f_r[i] <= iflip;
      end
    end
  end

  // Undo the fold
  assign sin_full = f_r[LAST] ? -y_r[LAST] : y_r[LAST];
  assign cos_full = f_r[LAST] ? -x_r[LAST] : x_r[LAST];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= TRIG_W'(sin_full);
      cos_o <= TRIG_W'(cos_full);
    end
  end

endmodule

@@ design/lidar_range_to_point.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_range_to_point
// Scales a raw range count to a distance, windows it, and projects it to
// x, y, z through elevation, azimuth and tilt rotations; also gives the
// per-point time offset.
// ----------------------------------------------------------------------------
// Pipeline: 2 entry stages, 34 in the sine/cosine pipeline and 8 multiply and
//   round stages lie between input transaction and result.
// Throughput: one point per cycle; the whole pipeline holds while the output
//   waits, set by the single shared stall enable.
// Reset: synchronous, clears valid bits and configuration registers; no
//   memories, so no clearing pass. Dropped points leave bubbles.
module lidar_range_to_point #(
  parameter int MAX_POINTS = lrp_pkg::MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lrp_in_if.sink    in_chan,
  lrp_out_if.source out_chan,
  lrp_cfg_if.sink   cfg_chan
);
  import lrp_pkg::*;

  localparam int L = SINCOS_LAT;
  localparam logic [63:0] TCAP_RAW = 64'(MAX_POINTS - 1) * 64'hFFFF_FFFF;
  localparam logic [TOFF_W-1:0] TCAP_MAX = '1;
  localparam logic [TOFF_W-1:0] TCAP =
    (TCAP_RAW > 64'(TCAP_MAX)) ? TCAP_MAX : TCAP_RAW[TOFF_W-1:0];

  typedef struct packed {
    logic [32:0]        mag;
    logic               neg;
    logic [TOFF_W-1:0]  toff;
    logic [INDEX_W-1:0] idx;
    logic [INTEN_W-1:0] inten;
  } sbd_t;

  // Configuration registers
  logic [63:0] scale_bias_r, window_r, az_r, el_r, tilt_r, offs_r;
  logic [31:0] tstep_r;

  logic adv;

  // Entry stages
  logic                      v1_r, v2_r;
  logic                      keep1;
  logic signed [33:0]        sum1_nxt, sum1_r, nsum;
  logic signed [ANG_W-1:0]   pa1_r, pt1_r, ang_a2_r, ang_t2_r;
  logic [TOFF_W-1:0]         toff1_r;
  logic [INDEX_W-1:0]        idx1_r;
  logic [INTEN_W-1:0]        inten1_r;
  sbd_t                      s2_nxt, s2_r;

  // Delay line alongside the sine/cosine pipeline
  sbd_t                      sbd_r [L];
  logic [L-1:0]              vd_r;
  sbd_t                      tap;

  logic signed [TRIG_W-1:0]  sa, ca, st, ct, sb, cb, sx, cx;

  // Multiply and round stages
  logic v_m1_r, v_m2_r, v_m3_r, v_m4_r, v_m5_r, v_m6_r, v_m7_r, v_m8_r;
  logic signed [63:0] p_cxsa_m1_r, p_cbsx_m1_r, p_sbsx_m1_r, p_cacx_m1_r;
  logic [64:0]        dprod_m1_r, qsum;
  logic               neg_m1_r;
  logic signed [31:0] sb_m1_r, cb_m1_r, st_m1_r, ct_m1_r;
  logic signed [31:0] sb_m2_r, cb_m2_r, st_m2_r, ct_m2_r;
  logic signed [31:0] st_m3_r, ct_m3_r, st_m4_r, ct_m4_r, st_m5_r, ct_m5_r;
  logic signed [31:0] st_m6_r, ct_m6_r;
  logic signed [31:0] cxsa_m2_r, cbsx_m2_r, sbsx_m2_r, cacx_m2_r;
  logic signed [41:0] dist_m2_nxt, dist_m2_r;
  logic signed [31:0] cbsx_m3_r, sbsx_m3_r, cacx_m3_r, cacx_m4_r;
  logic signed [63:0] p_sbc_m3_r, p_cbc_m3_r;
  logic signed [31:0] dist_m3_r, dist_m4_r;
  logic               in_win;
  logic signed [32:0] ka_m4_r, kc_m4_r;
  logic signed [65:0] pa_m5_r, pc_m5_r;
  logic signed [63:0] pb_m5_r;
  logic signed [33:0] a_m6_r, b_m6_r, c_m6_r;
  logic signed [65:0] px1_m7_r, px2_m7_r, py1_m7_r, py2_m7_r;
  logic signed [34:0] zc_m7_r;
  logic signed [37:0] xs, ys;

  logic [TOFF_W-1:0]  toff_m_r [8];
  logic [INDEX_W-1:0] idx_m_r  [8];
  logic [INTEN_W-1:0] inten_m_r[8];

  logic signed [POS_W-1:0] out_x_r, out_y_r, out_z_r;

  // Stall control: the whole pipeline moves together
  assign adv           = !v_m8_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_bias_r <= '0;
      window_r     <= '0;
      az_r         <= '0;
      el_r         <= '0;
      tilt_r       <= '0;
      offs_r       <= '0;
      tstep_r      <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_RANGE_SCALE_BIAS: scale_bias_r <= cfg_chan.data;
        REG_RANGE_WINDOW:     window_r     <= cfg_chan.data;
        REG_AZIMUTH:          az_r         <= cfg_chan.data;
        REG_ELEVATION:        el_r         <= cfg_chan.data;
        REG_TILT:             tilt_r       <= cfg_chan.data;
        REG_AXIS_OFFSETS:     offs_r       <= cfg_chan.data;
        REG_TIME_STEP:        tstep_r      <= cfg_chan.data[31:0];
        default: ;
      endcase
    end
  end

  // Stage 1: biased count, index products, drop of empty or stray samples
  assign keep1    = (in_chan.range_count != '0) &&
                    (32'(in_chan.point_index) < 32'(MAX_POINTS));
  assign sum1_nxt = $signed({2'b00, in_chan.range_count, 16'h0000}) +
                    34'($signed(scale_bias_r[31:0]));

  // Stage 2: start angles added, distance magnitude, time cap
  assign nsum = -sum1_r;
  always_comb begin
    s2_nxt.mag   = sum1_r[33] ? nsum[32:0] : sum1_r[32:0];
    s2_nxt.neg   = sum1_r[33];
    s2_nxt.toff  = (toff1_r > TCAP) ? TCAP : toff1_r;
    s2_nxt.idx   = idx1_r;
    s2_nxt.inten = inten1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_chan.valid && keep1;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum1_r   <= sum1_nxt;
      pa1_r    <= ANG_W'($signed({1'b0, in_chan.point_index})) *
                  ANG_W'($signed(el_r[31:0]));
      pt1_r    <= ANG_W'($signed({1'b0, in_chan.point_index})) *
                  ANG_W'($signed(az_r[31:0]));
      toff1_r  <= TOFF_W'(in_chan.point_index) * TOFF_W'(tstep_r);
      idx1_r   <= in_chan.point_index;
      inten1_r <= in_chan.intensity;
      ang_a2_r <= ANG_W'($signed(el_r[63:32])) + pa1_r;
      ang_t2_r <= ANG_W'($signed(az_r[63:32])) + pt1_r;
      s2_r     <= s2_nxt;
    end
  end

  // Sine/cosine units, all in lockstep
  lrp_sincos u_alpha (.clk(clk), .en(adv), .ang(ang_a2_r), .sin_o(sa), .cos_o(ca));
  lrp_sincos u_theta (.clk(clk), .en(adv), .ang(ang_t2_r), .sin_o(st), .cos_o(ct));
  lrp_sincos u_beta  (.clk(clk), .en(adv), .ang(ANG_W'($signed(tilt_r[63:32]))),
                      .sin_o(sb), .cos_o(cb));
  lrp_sincos u_xi    (.clk(clk), .en(adv), .ang(ANG_W'($signed(tilt_r[31:0]))),
                      .sin_o(sx), .cos_o(cx));

  // Side band delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (adv) begin
      vd_r <= {vd_r[L-2:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbd_r[0] <= s2_r;
      for (int k = 1; k < L; k++) begin
        sbd_r[k] <= sbd_r[k-1];
      end
    end
  end

  assign tap = sbd_r[L-1];

  // Distance rounding and window test
  assign qsum        = dprod_m1_r + 65'd8388608;
  assign dist_m2_nxt = neg_m1_r ? -$signed({1'b0, qsum[64:24]}) :
                                  $signed({1'b0, qsum[64:24]});
  assign in_win      = (dist_m2_r >= 42'($signed(window_r[63:32]))) &&
                       (dist_m2_r <= 42'($signed(window_r[31:0])));

  // Final combine
  assign xs = rnd30(68'(px1_m7_r)) - rnd30(68'(px2_m7_r));
  assign ys = rnd30(68'(py1_m7_r)) + rnd30(68'(py2_m7_r));

  // Valid bits of the multiply stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m1_r <= 1'b0;
      v_m2_r <= 1'b0;
      v_m3_r <= 1'b0;
      v_m4_r <= 1'b0;
      v_m5_r <= 1'b0;
      v_m6_r <= 1'b0;
      v_m7_r <= 1'b0;
      v_m8_r <= 1'b0;
    end else if (adv) begin
      v_m1_r <= vd_r[L-1];
      v_m2_r <= v_m1_r;
      v_m3_r <= v_m2_r && in_win;
      v_m4_r <= v_m3_r;
      v_m5_r <= v_m4_r;
      v_m6_r <= v_m5_r;
      v_m7_r <= v_m6_r;
      v_m8_r <= v_m7_r;
    end
  end

  // Multiply and round payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // M1: trig products, distance product
      p_cxsa_m1_r <= 64'(cx) * 64'(sa);
      p_cbsx_m1_r <= 64'(cb) * 64'(sx);
      p_sbsx_m1_r <= 64'(sb) * 64'(sx);
      p_cacx_m1_r <= 64'(ca) * 64'(cx);
      dprod_m1_r  <= 65'(tap.mag) * 65'(scale_bias_r[63:32]);
      neg_m1_r    <= tap.neg;
      sb_m1_r     <= sb;
      cb_m1_r     <= cb;
      st_m1_r     <= st;
      ct_m1_r     <= ct;
      // M2: round
      cxsa_m2_r <= 32'(rnd30(68'(p_cxsa_m1_r)));
      cbsx_m2_r <= 32'(rnd30(68'(p_cbsx_m1_r)));
      sbsx_m2_r <= 32'(rnd30(68'(p_sbsx_m1_r)));
      cacx_m2_r <= 32'(rnd30(68'(p_cacx_m1_r)));
      dist_m2_r <= dist_m2_nxt;
      sb_m2_r   <= sb_m1_r;
      cb_m2_r   <= cb_m1_r;
      st_m2_r   <= st_m1_r;
      ct_m2_r   <= ct_m1_r;
      // M3: tilt products, window
      p_sbc_m3_r <= 64'(sb_m2_r) * 64'(cxsa_m2_r);
      p_cbc_m3_r <= 64'(cb_m2_r) * 64'(cxsa_m2_r);
      cbsx_m3_r  <= cbsx_m2_r;
      sbsx_m3_r  <= sbsx_m2_r;
      cacx_m3_r  <= cacx_m2_r;
      dist_m3_r  <= dist_m2_r[31:0];
      st_m3_r    <= st_m2_r;
      ct_m3_r    <= ct_m2_r;
      // M4: direction factors
      ka_m4_r   <= 33'(rnd30(68'(p_sbc_m3_r))) - 33'(cbsx_m3_r);
      kc_m4_r   <= 33'(sbsx_m3_r) + 33'(rnd30(68'(p_cbc_m3_r)));
      cacx_m4_r <= cacx_m3_r;
      dist_m4_r <= dist_m3_r;
      st_m4_r   <= st_m3_r;
      ct_m4_r   <= ct_m3_r;
      // M5: scale by distance
      pa_m5_r <= 66'(ka_m4_r) * 66'(dist_m4_r);
      pb_m5_r <= 64'(cacx_m4_r) * 64'(dist_m4_r);
      pc_m5_r <= 66'(kc_m4_r) * 66'(dist_m4_r);
      st_m5_r <= st_m4_r;
      ct_m5_r <= ct_m4_r;
      // M6: round, horizontal axis offset
      a_m6_r  <= 34'(rnd30(68'(pa_m5_r))) + 34'($signed(offs_r[63:32]));
      b_m6_r  <= 34'(rnd30(68'(pb_m5_r)));
      c_m6_r  <= 34'(rnd30(68'(pc_m5_r)));
      st_m6_r <= st_m5_r;
      ct_m6_r <= ct_m5_r;
      // M7: azimuth rotation products, vertical offset
      px1_m7_r <= 66'(ct_m6_r) * 66'(a_m6_r);
      px2_m7_r <= 66'(st_m6_r) * 66'(b_m6_r);
      py1_m7_r <= 66'(st_m6_r) * 66'(a_m6_r);
      py2_m7_r <= 66'(ct_m6_r) * 66'(b_m6_r);
      zc_m7_r  <= 35'(c_m6_r) + 35'($signed(offs_r[31:0]));
      // M8: output register
      out_x_r <= sat32(xs);
      out_y_r <= sat32(ys);
      out_z_r <= sat32(38'(zc_m7_r));
      // pass-through fields
      toff_m_r[0]  <= tap.toff;
      idx_m_r[0]   <= tap.idx;
      inten_m_r[0] <= tap.inten;
      for (int k = 1; k < 8; k++) begin
        toff_m_r[k]  <= toff_m_r[k-1];
        idx_m_r[k]   <= idx_m_r[k-1];
        inten_m_r[k] <= inten_m_r[k-1];
      end
    end
  end

  // Result channel
  assign out_chan.valid           = v_m8_r;
  assign out_chan.pos_x           = out_x_r;
  assign out_chan.pos_y           = out_y_r;
  assign out_chan.pos_z           = out_z_r;
  assign out_chan.point_intensity = inten_m_r[7];
  assign out_chan.time_offset     = toff_m_r[7];
  assign out_chan.source_index    = idx_m_r[7];

  // Checks
  a_empty_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.range_count == '0 |=> !v1_r)
    else $error("empty range sample entered the pipeline");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> 32'(out_chan.source_index) < 32'(MAX_POINTS))
    else $error("result carries an index beyond the packet");

  a_time_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.time_offset <= TCAP)
    else $error("time offset above its saturation value");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> $stable(v_m4_r) && $stable(vd_r))
    else $error("pipeline moved during an output stall");

endmodule
